/* rtl/csvt_pkg.sv */
package csvt_pkg;

    // Lexer phases.
    localparam logic [2:0] PH_PLAIN  = 3'd0;
    localparam logic [2:0] PH_QUOTED = 3'd1;
    localparam logic [2:0] PH_QPEND  = 3'd2;
    localparam logic [2:0] PH_CLOSED = 3'd3;
    localparam logic [2:0] PH_CRPEND = 3'd4;

    // Event codes of a result word.
    localparam logic [2:0] EV_BYTE     = 3'd0;
    localparam logic [2:0] EV_ENDFIELD = 3'd1;
    localparam logic [2:0] EV_ENDROW   = 3'd2;
    localparam logic [2:0] EV_BLANK    = 3'd3;
    localparam logic [2:0] EV_DONE     = 3'd4;
    localparam logic [2:0] EV_ERROR    = 3'd5;

    // Error status codes.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_AFTER_QUOTED = 2'd1;
    localparam logic [1:0] ST_BAD_QUOTE    = 2'd2;
    localparam logic [1:0] ST_OPEN_QUOTE   = 2'd3;

    // Special characters.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Width of the blank count field and the most results one word can cause.
    localparam int BLANK_OUT_W = 16;
    localparam logic [1:0] MAX_RES = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             event_res;
        logic [7:0]             out_byte;
        logic [BLANK_OUT_W-1:0] blank_count;
        logic [1:0]             status;
        logic                   last;
    } t_out_item;

    // Results caused by one input word, in order, with their count.
    typedef struct packed {
        logic [1:0]          cnt;
        t_out_item [2:0]     slot;
    } t_rlist;

    function automatic t_out_item make_res(input logic [2:0] ev, input logic [7:0] b,
                                           input logic [BLANK_OUT_W-1:0] c,
                                           input logic [1:0] st);
        t_out_item r;
        begin
            r.event_res   = ev;
            r.out_byte    = b;
            r.blank_count = c;
            r.status      = st;
            r.last        = 1'b0;
            return r;
        end
    endfunction

    // Appends one result to the list; the list never grows past three entries.
    function automatic t_rlist push(input t_rlist l, input t_out_item r);
        t_rlist o;
        begin
            o = l;
            if (l.cnt < MAX_RES) begin
                o.slot[l.cnt] = r;
                o.cnt         = l.cnt + 2'd1;
            end
            return o;
        end
    endfunction

endpackage

/* rtl/csvt_lex.sv */
module csvt_lex
    import csvt_pkg::*;
#(
    parameter int BLANK_COUNT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    output t_rlist   o_list
);

    localparam int CW = (BLANK_COUNT_BITS > BLANK_OUT_W) ? BLANK_COUNT_BITS : BLANK_OUT_W;

    logic [2:0]                  r_ph, n_ph;
    logic                        r_fhb, n_fhb;
    logic                        r_rhc, n_rhc;
    logic [BLANK_COUNT_BITS-1:0] r_pbr, n_pbr;
    logic [1:0]                  r_fc, n_fc;

    // The emitted blank count saturates at the width of the output field.
    function automatic logic [BLANK_OUT_W-1:0] sat_cnt(input logic [BLANK_COUNT_BITS-1:0] v);
        logic [CW-1:0] w;
        begin
            w = CW'(v);
            if (w > CW'({BLANK_OUT_W{1'b1}})) begin
                return '1;
            end
            return w[BLANK_OUT_W-1:0];
        end
    endfunction

    // One lexing step: the next state and the results of the word in the input register.
    always_comb begin
        t_rlist     l;
        logic [7:0] b;
        logic       do_plain;
        logic       closed;
        l        = '0;
        b        = i_item.data_byte;
        do_plain = 1'b0;
        closed   = 1'b0;
        n_ph     = r_ph;
        n_fhb    = r_fhb;
        n_rhc    = r_rhc;
        n_pbr    = r_pbr;
        n_fc     = r_fc;

        if (i_item.mode) begin
            // End of the document: report, then return to the reset state.
            if (r_fc != ST_OK) begin
                l = push(l, make_res(EV_ERROR, 8'd0, '0, r_fc));
            end else if (r_ph == PH_QUOTED) begin
                l = push(l, make_res(EV_ERROR, 8'd0, '0, ST_OPEN_QUOTE));
            end else begin
                if (r_rhc) begin
                    l = push(l, make_res(EV_ENDFIELD, 8'd0, '0, ST_OK));
                    l = push(l, make_res(EV_ENDROW, 8'd0, '0, ST_OK));
                end
                l = push(l, make_res(EV_DONE, 8'd0, '0, ST_OK));
            end
            n_ph  = PH_PLAIN;
            n_fhb = 1'b0;
            n_rhc = 1'b0;
            n_pbr = '0;
            n_fc  = ST_OK;
        end else if (r_fc == ST_OK) begin
            case (r_ph)
                PH_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        n_ph = PH_QPEND;
                    end else begin
                        if (!n_rhc) begin
                            if (n_pbr != '0) begin
                                l = push(l, make_res(EV_BLANK, 8'd0, sat_cnt(n_pbr), ST_OK));
                            end
                            n_pbr = '0;
                            n_rhc = 1'b1;
                        end
                        l = push(l, make_res(EV_BYTE, b, '0, ST_OK));
                    end
                end
                PH_QPEND: begin
                    if (b == CH_QUOTE) begin
                        // A doubled quote stands for one quote byte.
                        if (!n_rhc) begin
                            if (n_pbr != '0) begin
                                l = push(l, make_res(EV_BLANK, 8'd0, sat_cnt(n_pbr), ST_OK));
                            end
                            n_pbr = '0;
                            n_rhc = 1'b1;
                        end
                        l    = push(l, make_res(EV_BYTE, CH_QUOTE, '0, ST_OK));
                        n_ph = PH_QUOTED;
                    end else begin
                        n_ph     = PH_CLOSED;
                        do_plain = 1'b1;
                        closed   = 1'b1;
                    end
                end
                PH_CRPEND: begin
                    // The pending CR ends the row; a following LF is swallowed.
                    if (n_rhc) begin
                        l = push(l, make_res(EV_ENDFIELD, 8'd0, '0, ST_OK));
                        l = push(l, make_res(EV_ENDROW, 8'd0, '0, ST_OK));
                    end else if (n_pbr != '1) begin
                        n_pbr = n_pbr + BLANK_COUNT_BITS'(1);
                    end
                    n_fhb    = 1'b0;
                    n_rhc    = 1'b0;
                    n_ph     = PH_PLAIN;
                    do_plain = (b != CH_LF);
                end
                PH_CLOSED: begin
                    do_plain = 1'b1;
                    closed   = 1'b1;
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase

            // Handling of a byte outside quotes.
            if (do_plain) begin
                if (closed && b != CH_COMMA && b != CH_CR && b != CH_LF) begin
                    n_fc = ST_AFTER_QUOTED;
                    l    = push(l, make_res(EV_ERROR, 8'd0, '0, ST_AFTER_QUOTED));
                end else if (b == CH_QUOTE) begin
                    if (n_fhb) begin
                        n_fc = ST_BAD_QUOTE;
                        l    = push(l, make_res(EV_ERROR, 8'd0, '0, ST_BAD_QUOTE));
                    end else begin
                        n_ph = PH_QUOTED;
                    end
                end else if (b == CH_LF) begin
                    if (n_rhc) begin
                        l = push(l, make_res(EV_ENDFIELD, 8'd0, '0, ST_OK));
                        l = push(l, make_res(EV_ENDROW, 8'd0, '0, ST_OK));
                    end else if (n_pbr != '1) begin
                        n_pbr = n_pbr + BLANK_COUNT_BITS'(1);
                    end
                    n_fhb = 1'b0;
                    n_rhc = 1'b0;
                    n_ph  = PH_PLAIN;
                end else if (b == CH_CR) begin
                    n_ph = PH_CRPEND;
                end else begin
                    // Comma or content byte: the row is not blank.
                    if (!n_rhc) begin
                        if (n_pbr != '0) begin
                            l = push(l, make_res(EV_BLANK, 8'd0, sat_cnt(n_pbr), ST_OK));
                        end
                        n_pbr = '0;
                        n_rhc = 1'b1;
                    end
                    if (b == CH_COMMA) begin
                        l     = push(l, make_res(EV_ENDFIELD, 8'd0, '0, ST_OK));
                        n_fhb = 1'b0;
                    end else begin
                        l     = push(l, make_res(EV_BYTE, b, '0, ST_OK));
                        n_fhb = 1'b1;
                    end
                    n_ph = PH_PLAIN;
                end
            end
        end
        o_list = l;
    end

    // Lexer state advances once per word taken from the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_PLAIN;
            r_fhb <= 1'b0;
            r_rhc <= 1'b0;
            r_pbr <= '0;
            r_fc  <= ST_OK;
        end else if (i_step) begin
            r_ph  <= n_ph;
            r_fhb <= n_fhb;
            r_rhc <= n_rhc;
            r_pbr <= n_pbr;
            r_fc  <= n_fc;
        end
    end

endmodule

/* rtl/csv_stream_tokenizer_unit.sv */
// Streaming CSV tokenizer. Each input word is a text byte or an end-of-document
// mark; each output word is one event (field byte, end field, end row, blank-row
// count, done or error), and last marks the final event of an input word. Quoted
// fields with doubled quotes, CR, LF and CR LF row ends are handled; runs of blank
// rows come out as one count before the next non-blank row. Plain text streams at
// one byte per cycle while the output is ready; a word that causes k events (k up
// to three) holds the three-entry result buffer until its last event is taken, and
// the next word waits in the input register. Input reaches the first event through
// the input register, then the lexer logic into the result buffer.
module csv_stream_tokenizer_unit
    import csvt_pkg::*;
#(
    parameter int BLANK_COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic            r_in_valid;
    t_in_item        r_in;
    t_out_item [2:0] r_slot;
    logic [1:0]      r_cnt;
    logic            buf_free;
    logic            advance;
    t_rlist          list;

    // The buffer can take a new result list once its last entry leaves.
    assign buf_free    = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign advance     = r_in_valid && buf_free;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = (r_cnt != 2'd0);

    // Output word: head of the buffer, last when it is the final entry.
    always_comb begin
        o_out_data      = r_slot[0];
        o_out_data.last = (r_cnt == 2'd1);
    end

    csvt_lex #(
        .BLANK_COUNT_BITS(BLANK_COUNT_BITS)
    ) u_lex (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_item (r_in),
        .o_list (list)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result buffer: loaded whole, drained from the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (advance) begin
            r_cnt <= list.cnt;
        end else if (o_out_valid && i_out_ready) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_slot <= list.slot;
        end else if (o_out_valid && i_out_ready) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

`ifndef ASSERT_OFF
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && list.cnt == 2'd0 |=> !o_out_valid)
        else $error("word without results produced an output");

    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_BYTE |-> o_out_data.out_byte == 8'd0)
        else $error("non-byte event carries a byte");

    a_blank_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_BLANK |-> o_out_data.blank_count == '0)
        else $error("non-blank event carries a count");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.event_res == EV_ERROR) == (o_out_data.status != ST_OK)))
        else $error("status does not match error event");
`endif

endmodule

/* dv/csv_stream_tokenizer_unit_test.sv */
`timescale 1ns / 100ps

module csv_stream_tokenizer_unit_test;
    import csvt_pkg::*;

    // Tracks the lexer state and holds the events still owed by the block.
    class csv_event_scoreboard;
        logic [2:0]  phase;
        logic        field_open;
        logic        row_live;
        logic [15:0] blank_run;
        logic [1:0]  fail_code;
        t_out_item   pending_events[$];
        t_out_item   word_events[$];
        int          errors;

        function new();
            errors = 0;
            clear_lexer();
        endfunction

        function void clear_lexer();
            phase      = PH_PLAIN;
            field_open = 1'b0;
            row_live   = 1'b0;
            blank_run  = '0;
            fail_code  = ST_OK;
        endfunction

        // One word never causes more than three events.
        function void add_event(logic [2:0] ev, logic [7:0] b, logic [15:0] cnt,
                                logic [1:0] st);
            t_out_item r;
            r.event_res   = ev;
            r.out_byte    = b;
            r.blank_count = cnt;
            r.status      = st;
            r.last        = 1'b0;
            if (word_events.size() < 3) begin
                word_events.insert(word_events.size(), r);
            end
        endfunction

        // The first content of a row releases the held blank-row count.
        function void touch_row();
            if (!row_live) begin
                if (blank_run != 0) begin
                    add_event(EV_BLANK, 8'h00, blank_run, ST_OK);
                end
                blank_run = '0;
                row_live  = 1'b1;
            end
        endfunction

        function void flag_error(logic [1:0] code);
            fail_code = code;
            add_event(EV_ERROR, 8'h00, 16'h0000, code);
        endfunction

        // A row with content closes its field and row; an empty one is counted.
        function void close_row();
            if (row_live) begin
                add_event(EV_ENDFIELD, 8'h00, 16'h0000, ST_OK);
                add_event(EV_ENDROW, 8'h00, 16'h0000, ST_OK);
            end else if (blank_run != 16'hFFFF) begin
                blank_run = blank_run + 16'd1;
            end
            field_open = 1'b0;
            row_live   = 1'b0;
            phase      = PH_PLAIN;
        endfunction

        // Byte outside quotes; after a closed quoted field only separators pass.
        function void unquoted_byte(logic [7:0] b, bit after_close);
            if (after_close && b != CH_COMMA && b != CH_CR && b != CH_LF) begin
                flag_error(ST_AFTER_QUOTED);
            end else if (b == CH_QUOTE) begin
                if (field_open) begin
                    flag_error(ST_BAD_QUOTE);
                end else begin
                    phase = PH_QUOTED;
                end
            end else if (b == CH_COMMA) begin
                touch_row();
                add_event(EV_ENDFIELD, 8'h00, 16'h0000, ST_OK);
                field_open = 1'b0;
                phase      = PH_PLAIN;
            end else if (b == CH_LF) begin
                close_row();
            end else if (b == CH_CR) begin
                phase = PH_CRPEND;
            end else begin
                touch_row();
                add_event(EV_BYTE, b, 16'h0000, ST_OK);
                field_open = 1'b1;
                phase      = PH_PLAIN;
            end
        endfunction

        // Works out the events of one accepted input word.
        function void note_input(t_in_item w);
            word_events.delete();
            if (w.mode) begin
                if (fail_code != ST_OK) begin
                    add_event(EV_ERROR, 8'h00, 16'h0000, fail_code);
                end else if (phase == PH_QUOTED) begin
                    flag_error(ST_OPEN_QUOTE);
                end else begin
                    if (row_live) begin
                        add_event(EV_ENDFIELD, 8'h00, 16'h0000, ST_OK);
                        add_event(EV_ENDROW, 8'h00, 16'h0000, ST_OK);
                    end
                    add_event(EV_DONE, 8'h00, 16'h0000, ST_OK);
                end
                clear_lexer();
            end else if (fail_code == ST_OK) begin
                case (phase)
                    PH_QUOTED: begin
                        if (w.data_byte == CH_QUOTE) begin
                            phase = PH_QPEND;
                        end else begin
                            touch_row();
                            add_event(EV_BYTE, w.data_byte, 16'h0000, ST_OK);
                        end
                    end
                    PH_QPEND: begin
                        if (w.data_byte == CH_QUOTE) begin
                            touch_row();
                            add_event(EV_BYTE, CH_QUOTE, 16'h0000, ST_OK);
                            phase = PH_QUOTED;
                        end else begin
                            phase = PH_CLOSED;
                            unquoted_byte(w.data_byte, 1'b1);
                        end
                    end
                    PH_CRPEND: begin
                        close_row();
                        if (w.data_byte != CH_LF) begin
                            unquoted_byte(w.data_byte, 1'b0);
                        end
                    end
                    PH_CLOSED: unquoted_byte(w.data_byte, 1'b1);
                    default:   unquoted_byte(w.data_byte, 1'b0);
                endcase
            end
            if (word_events.size() > 0) begin
                word_events[word_events.size() - 1].last = 1'b1;
            end
            pending_events = {pending_events, word_events};
        endfunction

        // Compares one output word against the oldest owed event.
        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending_events.size() == 0) begin
                $error("event word with nothing owed: event_res %0d", got.event_res);
                errors++;
                return;
            end
            exp = pending_events.pop_front();
            if (got.event_res !== exp.event_res) begin
                $error("event_res: expected %0d, got %0d", exp.event_res, got.event_res);
                errors++;
            end
            if (got.out_byte !== exp.out_byte) begin
                $error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
                errors++;
            end
            if (got.blank_count !== exp.blank_count) begin
                $error("blank_count: expected %0d, got %0d", exp.blank_count,
                       got.blank_count);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0b, got %0b", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit hold_request = 1'b0;
    int words_sent = 0;

    csv_event_scoreboard scoreboard = new();

    csv_stream_tokenizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both handshakes are observed with the values they had before the edge.
    always @(posedge i_clk) begin
        if (rst_n && in_valid && o_in_ready) begin
            scoreboard.note_input(in_data);
        end
        if (rst_n && o_out_valid && out_ready) begin
            scoreboard.check_result(o_out_data);
        end
    end

    // Offers one word; valid stays high across back-to-back words.
    task automatic send_word(input logic mode, input logic [7:0] b);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: mode, data_byte: b};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_word(1'b0, s[k]);
        end
    endtask

    task automatic send_end();
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    function automatic bit is_special(logic [7:0] b);
        return b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF;
    endfunction

    task automatic send_plain_content();
        logic [7:0] b;
        int n;
        n = $urandom_range(0, 5);
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (is_special(b));
            send_word(1'b0, b);
        end
    endtask

    // Quoted content may hold any byte; a quote inside is doubled.
    task automatic send_quoted_content();
        logic [7:0] b;
        int n;
        n = $urandom_range(0, 5);
        send_word(1'b0, CH_QUOTE);
        repeat (n) begin
            b = ($urandom_range(0, 3) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
            send_word(1'b0, b);
            if (b == CH_QUOTE) begin
                send_word(1'b0, CH_QUOTE);
            end
        end
        send_word(1'b0, CH_QUOTE);
    endtask

    task automatic send_row_end();
        case ($urandom_range(0, 2))
            0: send_word(1'b0, CH_LF);
            1: send_word(1'b0, CH_CR);
            default: begin
                send_word(1'b0, CH_CR);
                send_word(1'b0, CH_LF);
            end
        endcase
    endtask

    // A well-formed document with random rows, fields and row ends.
    task automatic send_document();
        int rows;
        int fields;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 3) != 0) begin
                fields = $urandom_range(1, 4);
                for (int f = 0; f < fields; f++) begin
                    if (f > 0) begin
                        send_word(1'b0, CH_COMMA);
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        send_plain_content();
                    end else begin
                        send_quoted_content();
                    end
                end
            end
            if (r < rows - 1 || $urandom_range(0, 1) == 0) begin
                send_row_end();
            end
        end
        send_end();
    endtask

    // Noise leaning on the special characters, usually ending the document.
    task automatic send_noise();
        logic [7:0] b;
        int n;
        n = $urandom_range(3, 15);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: b = CH_QUOTE;
                1: b = CH_COMMA;
                2: b = CH_CR;
                3: b = CH_LF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(1'b0, b);
        end
        if ($urandom_range(0, 4) != 0) begin
            send_end();
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        wait (rst_n);
        forever begin
            int gap;
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_request = 1'b0;
            end
            gap = recv_idle_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int doc;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Quoted field with an escaped quote, then a plain field ended by CR LF.
        send_text("\"q\"\"\",b");
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        // A blank row, a blank row ended by a lone CR, then extreme byte values.
        send_word(1'b0, CH_LF);
        send_word(1'b0, CH_CR);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        // The trailing blank row is dropped at the end of the document.
        send_word(1'b0, CH_LF);
        send_word(1'b0, CH_LF);
        send_end();
        // Data after a closed quoted field; later bytes are ignored.
        send_text("\"a\"bx");
        send_end();
        // Quote inside an unquoted field that already holds bytes.
        send_text("a\"");
        send_end();
        // Document ends inside a quoted field.
        send_text("\"ab");
        send_end();
        // Empty document.
        send_end();

        // Mostly well-formed documents; the second one meets a long output stall.
        doc = 0;
        while (words_sent < 180) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (doc == 1) begin
                send_idle_on = 1'b0;
                hold_request = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                send_document();
            end else begin
                send_noise();
            end
            doc++;
        end
        send_end();
        in_valid <= 1'b0;

        while (scoreboard.pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.pending_events.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
